// File: rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types, constants and helpers for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int GEN_W = 16;

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_ACTIVATE = 3'd1,
    OP_GET      = 3'd2,
    OP_ERASE    = 3'd3,
    OP_KILL     = 3'd4,
    OP_IS_ALIVE = 3'd5,
    OP_MAINTAIN = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REAP_RD,
    ST_REAP_WR
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // input transfer: latch request, start table read
    logic exec;       // finish a single-result op and load the output
    logic reap_sel;   // pick lowest kill mark, read its generation
    logic reap_emit;  // load the reaped handle into the output
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic maint;
    logic kill_any;
  } sts_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } ffs_t;

  // lowest set bit
  function automatic ffs_t gha_ffs(input logic [SLOTS-1:0] v);
    ffs_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/gha_if.sv
// ----------------------------------------------------------------------------
// gha_if
// Request and result channels of the handle allocator, valid/ready.
// ----------------------------------------------------------------------------
interface gha_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                op;
  logic [gha_pkg::IDX_W-1:0] slot_index;
  logic [gha_pkg::GEN_W-1:0] handle_generation;
  logic                      make_alive;

  modport source (output valid, op, slot_index, handle_generation, make_alive,
                  input ready);
  modport sink   (input valid, op, slot_index, handle_generation, make_alive,
                  output ready);
endinterface

interface gha_out_if;
  logic                      valid;
  logic                      ready;
  logic [gha_pkg::IDX_W-1:0] result_index;
  logic [gha_pkg::GEN_W-1:0] result_generation;
  logic                      ok;
  logic                      last;

  modport source (output valid, result_index, result_generation, ok, last,
                  input ready);
  modport sink   (input valid, result_index, result_generation, ok, last,
                  output ready);
endinterface

// File: rtl/gha_ctrl.sv
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer: one request at a time, reaps walked one kill mark per pass.
// ----------------------------------------------------------------------------
module gha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gha_pkg::sts_t sts,
  output gha_pkg::cmd_t cmd
);

  gha_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gha_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      gha_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = gha_pkg::ST_EXEC;
      end
      gha_pkg::ST_EXEC: begin
        if (sts.maint && sts.kill_any) begin
          state_nxt = gha_pkg::ST_REAP_RD;
        end else if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = gha_pkg::ST_IDLE;
        end
      end
      gha_pkg::ST_REAP_RD: begin
        cmd.reap_sel = 1'b1;
        state_nxt    = gha_pkg::ST_REAP_WR;
      end
      gha_pkg::ST_REAP_WR: begin
        if (sts.out_free) begin
          cmd.reap_emit = 1'b1;
          state_nxt     = sts.kill_any ? gha_pkg::ST_REAP_RD : gha_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gha_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.exec, cmd.reap_sel, cmd.reap_emit}))
    else $error("gha_ctrl: more than one command at once");
  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.reap_emit) |-> sts.out_free)
    else $error("gha_ctrl: result loaded over a pending one");
  a_reap_follows_sel: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.reap_sel |=> state_r == gha_pkg::ST_REAP_WR)
    else $error("gha_ctrl: reap read not followed by emit");
`endif

endmodule

// File: rtl/gha_datapath.sv
// ----------------------------------------------------------------------------
// gha_datapath
// Generation table, alive and kill vectors, slot count and result register.
// ----------------------------------------------------------------------------
module gha_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gha_pkg::cmd_t             cmd,
  output gha_pkg::sts_t             sts,
  input  logic [2:0]                in_op,
  input  logic [gha_pkg::IDX_W-1:0] in_slot_index,
  input  logic [gha_pkg::GEN_W-1:0] in_handle_generation,
  input  logic                      in_make_alive,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [gha_pkg::IDX_W-1:0] out_result_index,
  output logic [gha_pkg::GEN_W-1:0] out_result_generation,
  output logic                      out_ok,
  output logic                      out_last
);

  // generation table: written only on create, read data registered
  logic [gha_pkg::GEN_W-1:0] gen_mem [gha_pkg::SLOTS];
  logic [gha_pkg::GEN_W-1:0] rdata_r;

  logic [gha_pkg::SLOTS-1:0] alive_r, alive_nxt;
  logic [gha_pkg::SLOTS-1:0] kill_r, kill_nxt;
  logic [gha_pkg::CNT_W-1:0] used_r, used_nxt;
  logic [gha_pkg::SLOTS-1:0] used_mask;

  // latched request
  logic [2:0]                op_r;
  logic [gha_pkg::IDX_W-1:0] idx_r;
  logic [gha_pkg::GEN_W-1:0] hgen_r;
  logic                      mk_r;
  gha_pkg::ffs_t             free_r;
  logic [gha_pkg::IDX_W-1:0] reap_idx_r;

  logic                      out_valid_r, out_valid_nxt;
  logic [gha_pkg::IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [gha_pkg::GEN_W-1:0] out_gen_r, out_gen_nxt;
  logic                      out_ok_r, out_ok_nxt;
  logic                      out_last_r, out_last_nxt;

  gha_pkg::ffs_t             free_srch, kill_srch;
  logic                      rd_en;
  logic [gha_pkg::IDX_W-1:0] rd_addr;
  logic                      we;
  logic [gha_pkg::IDX_W-1:0] wr_addr;
  logic [gha_pkg::GEN_W-1:0] wr_data;

  logic                      in_use, match;
  logic [gha_pkg::GEN_W-1:0] cur_gen, gen_inc;

  always_comb begin
    for (int i = 0; i < gha_pkg::SLOTS; i++) begin
      used_mask[i] = gha_pkg::CNT_W'(i) < used_r;
    end
  end

  assign free_srch = gha_pkg::gha_ffs(~alive_r & used_mask);
  assign kill_srch = gha_pkg::gha_ffs(kill_r);

  assign rd_en   = cmd.capture || cmd.reap_sel;
  assign rd_addr = cmd.reap_sel ? kill_srch.idx :
                   (gha_pkg::op_t'(in_op) == gha_pkg::OP_CREATE) ? free_srch.idx :
                   in_slot_index;

  assign in_use  = {1'b0, idx_r} < used_r;
  assign match   = in_use && alive_r[idx_r] && (hgen_r == rdata_r);
  assign cur_gen = in_use ? rdata_r : '0;
  assign gen_inc = rdata_r + 1'b1;

  always_comb begin
    alive_nxt     = alive_r;
    kill_nxt      = kill_r;
    used_nxt      = used_r;
    we            = 1'b0;
    wr_addr       = free_r.idx;
    wr_data       = gen_inc;
    out_idx_nxt   = out_idx_r;
    out_gen_nxt   = out_gen_r;
    out_ok_nxt    = out_ok_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = idx_r;
      out_gen_nxt   = cur_gen;
      out_ok_nxt    = 1'b0;
      out_last_nxt  = 1'b1;
      unique case (op_r)
        gha_pkg::OP_CREATE: begin
          if (!free_r.found && used_r == gha_pkg::CNT_W'(gha_pkg::SLOTS)) begin
            // table full
            out_idx_nxt = '0;
            out_gen_nxt = '0;
          end else begin
            we = 1'b1;
            if (free_r.found) begin
              wr_addr = free_r.idx;
              wr_data = (gen_inc == '0) ? gha_pkg::GEN_W'(1) : gen_inc;
            end else begin
              // fresh slot
              wr_addr  = used_r[gha_pkg::IDX_W-1:0];
              wr_data  = gha_pkg::GEN_W'(1);
              used_nxt = used_r + 1'b1;
            end
            alive_nxt[wr_addr] = mk_r;
            kill_nxt[wr_addr]  = 1'b0;
            out_idx_nxt        = wr_addr;
            out_gen_nxt        = wr_data;
            out_ok_nxt         = 1'b1;
          end
        end
        gha_pkg::OP_ACTIVATE: begin
          if (in_use) alive_nxt[idx_r] = 1'b1;
          out_ok_nxt = in_use;
        end
        gha_pkg::OP_GET: out_ok_nxt = in_use;
        gha_pkg::OP_ERASE: begin
          if (match) alive_nxt[idx_r] = 1'b0;
          out_ok_nxt = match;
        end
        gha_pkg::OP_KILL: begin
          if (match) kill_nxt[idx_r] = 1'b1;
          out_ok_nxt = match;
        end
        gha_pkg::OP_IS_ALIVE: out_ok_nxt = (hgen_r != '0) && in_use && alive_r[idx_r];
        default: begin
          // maintain with nothing marked, or an unknown op
          out_idx_nxt = '0;
          out_gen_nxt = '0;
        end
      endcase
    end

    if (cmd.reap_sel) begin
      alive_nxt[kill_srch.idx] = 1'b0;
      kill_nxt[kill_srch.idx]  = 1'b0;
    end

    if (cmd.reap_emit) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = reap_idx_r;
      out_gen_nxt   = rdata_r;
      out_ok_nxt    = 1'b1;
      out_last_nxt  = !(|kill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (we) gen_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= gen_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r     <= '0;
      kill_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      alive_r     <= alive_nxt;
      kill_r      <= kill_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      idx_r  <= in_slot_index;
      hgen_r <= in_handle_generation;
      mk_r   <= in_make_alive;
      free_r <= free_srch;
    end
    if (cmd.reap_sel) reap_idx_r <= kill_srch.idx;
    out_idx_r  <= out_idx_nxt;
    out_gen_r  <= out_gen_nxt;
    out_ok_r   <= out_ok_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.maint    = gha_pkg::op_t'(op_r) == gha_pkg::OP_MAINTAIN;
  assign sts.kill_any = |kill_r;

  assign out_valid             = out_valid_r;
  assign out_result_index      = out_idx_r;
  assign out_result_generation = out_gen_r;
  assign out_ok                = out_ok_r;
  assign out_last              = out_last_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= gha_pkg::CNT_W'(gha_pkg::SLOTS))
    else $error("gha_datapath: slot count beyond table size");
  a_alive_in_used: assert property (@(posedge clk) disable iff (!rst_n)
    (alive_r & ~used_mask) == '0)
    else $error("gha_datapath: alive bit on a never-used slot");
  a_kill_in_used: assert property (@(posedge clk) disable iff (!rst_n)
    (kill_r & ~used_mask) == '0)
    else $error("gha_datapath: kill mark on a never-used slot");
  a_reap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.reap_sel |=> !kill_r[reap_idx_r] && !alive_r[reap_idx_r])
    else $error("gha_datapath: reaped slot still marked");
`endif

endmodule

// File: rtl/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Table of 64 handles (slot index + 16-bit generation) with create, activate,
// get, erase, kill, is_alive and maintain (reap of killed slots).
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request channel (op, slot_index, handle_generation, make_alive).
//            A transfer occurs when valid and ready are both high.
//   out_ch : result channel (result_index, result_generation, ok, last).
//            Every request gives one result with last set; a maintain that
//            reaps gives one result per reaped slot, last on the final one.
//   Sequence: the table read is registered at the request transfer, then the
//   result register loads in the execute state, which waits while out_ch
//   stalls; the next request is taken only after that load.
//   Maintain with marked slots steps through select, then emit, for each
//   reaped slot before it returns to idle.
//   A new request is taken while a result still waits; while out_ch stalls,
//   work holds at the point of loading the next result. Reset (rst_n low,
//   synchronous) clears alive bits, kill marks, slot count and result valid.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
  input  logic clk,
  input  logic rst_n,
  gha_in_if.sink    in_ch,
  gha_out_if.source out_ch
);

  gha_pkg::cmd_t cmd;
  gha_pkg::sts_t sts;

  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gha_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_op                 (in_ch.op),
    .in_slot_index         (in_ch.slot_index),
    .in_handle_generation  (in_ch.handle_generation),
    .in_make_alive         (in_ch.make_alive),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_result_index      (out_ch.result_index),
    .out_result_generation (out_ch.result_generation),
    .out_ok                (out_ch.ok),
    .out_last              (out_ch.last)
  );

endmodule
